// ===== hw/rtl/bprs_pkg.sv =====
// bprs_pkg: shared types, command codes and arithmetic helpers of the beat repeat stutter block
// used by bprs_div, bprs_dp, bprs_ctrl and the top level; depends on nothing
package bprs_pkg;

    // sample format
    localparam int SAMPLE_BITS = 24;
    localparam int WET_W       = 8;

    // shared divider and multiplier widths
    localparam int DIV_NW  = 36;
    localparam int DIV_DW  = 14;
    localparam int DIV_CW  = 6;
    localparam int MUL_AW  = 29;
    localparam int MUL_BW  = 18;
    localparam int PROD_W  = MUL_AW + MUL_BW;
    localparam int ACC_W   = PROD_W + 1;

    // register indexes of the configuration port
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_BPM      = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_DIVISION = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_MIX      = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_FEEDBACK = 3'd3;
    localparam int CFG_DW = 17;

    // datapath commands
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NOP     = 5'd0;
    localparam logic [OP_W-1:0] OP_CLEAR   = 5'd1;
    localparam logic [OP_W-1:0] OP_LOAD    = 5'd2;
    localparam logic [OP_W-1:0] OP_ENG     = 5'd3;
    localparam logic [OP_W-1:0] OP_LMUL    = 5'd4;
    localparam logic [OP_W-1:0] OP_DIVLEN  = 5'd5;
    localparam logic [OP_W-1:0] OP_CAPTURE = 5'd6;
    localparam logic [OP_W-1:0] OP_BYPASS  = 5'd7;
    localparam logic [OP_W-1:0] OP_GMUL    = 5'd8;
    localparam logic [OP_W-1:0] OP_DIVG    = 5'd9;
    localparam logic [OP_W-1:0] OP_GSET    = 5'd10;
    localparam logic [OP_W-1:0] OP_RDA     = 5'd11;
    localparam logic [OP_W-1:0] OP_RDB     = 5'd12;
    localparam logic [OP_W-1:0] OP_LATB    = 5'd13;
    localparam logic [OP_W-1:0] OP_XM1     = 5'd14;
    localparam logic [OP_W-1:0] OP_XM2     = 5'd15;
    localparam logic [OP_W-1:0] OP_XSUM    = 5'd16;
    localparam logic [OP_W-1:0] OP_XDIV    = 5'd17;
    localparam logic [OP_W-1:0] OP_XSET    = 5'd18;
    localparam logic [OP_W-1:0] OP_REPA    = 5'd19;
    localparam logic [OP_W-1:0] OP_WM      = 5'd20;
    localparam logic [OP_W-1:0] OP_WB      = 5'd21;
    localparam logic [OP_W-1:0] OP_OM1     = 5'd22;
    localparam logic [OP_W-1:0] OP_OM2     = 5'd23;
    localparam logic [OP_W-1:0] OP_OSUM    = 5'd24;
    localparam logic [OP_W-1:0] OP_FIN     = 5'd25;
    localparam logic [OP_W-1:0] OP_PUSH    = 5'd26;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            ch;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic eng_rise;
        logic bypass;
        logic xfade;
        logic div_busy;
    } t_stat;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

    // divide by 32768 rounding toward zero
    function automatic logic signed [ACC_W-1:0] trunc15(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + (v[ACC_W-1] ? ACC_W'(32767) : ACC_W'(0));
        return t >>> 15;
    endfunction

    // clip to the signed sample range
    function automatic logic signed [SAMPLE_BITS-1:0] sat_s(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = (v > SAT_MAX) ? SAT_MAX : ((v < SAT_MIN) ? SAT_MIN : v);
        return c[SAMPLE_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/bprs_div.sv =====
// bprs_div: shared restoring divider, one quotient bit per cycle
// depends on bprs_pkg for operand widths
module bprs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bprs_pkg::DIV_NW-1:0]   i_num,
    input  logic [bprs_pkg::DIV_DW-1:0]   i_den,
    output logic                          o_busy,
    output logic [bprs_pkg::DIV_NW-1:0]   o_quo
);
    import bprs_pkg::*;

    logic                 r_busy;
    logic [DIV_CW-1:0]    r_cnt;
    logic [DIV_DW-1:0]    r_rem;
    logic [DIV_DW-1:0]    r_den;
    logic [DIV_NW-1:0]    r_quo;
    logic [DIV_DW:0]      trial;
    logic                 ge;
    logic [DIV_DW:0]      rem_diff;

    // one trial subtraction
    assign trial    = {r_rem, r_quo[DIV_NW-1]};
    assign ge       = trial >= {1'b0, r_den};
    assign rem_diff = ge ? (trial - {1'b0, r_den}) : trial;

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CW'(DIV_NW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != DIV_CW'(1));
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= rem_diff[DIV_DW-1:0];
            r_quo <= {r_quo[DIV_NW-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// ===== hw/rtl/bprs_dp.sv =====
// bprs_dp: datapath with the sample ring memory, loop state, config registers,
// shared multiplier and divider; depends on bprs_pkg and bprs_div
module bprs_dp #(
    parameter int SAMPLE_RATE    = 48000,
    parameter int BUFFER_DEPTH   = 262144,
    parameter int CROSSFADE_LEN  = 96,
    parameter int TRANSITION_LEN = 240
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bprs_pkg::t_cmd                       i_cmd,
    output bprs_pkg::t_stat                      o_stat,
    input  logic signed [bprs_pkg::SAMPLE_BITS-1:0] i_left_in,
    input  logic signed [bprs_pkg::SAMPLE_BITS-1:0] i_right_in,
    input  logic                                 i_engage,
    input  logic                                 i_cfg_valid,
    input  logic [bprs_pkg::CFG_IW-1:0]          i_cfg_index,
    input  logic [bprs_pkg::CFG_DW-1:0]          i_cfg_data,
    output logic signed [bprs_pkg::SAMPLE_BITS-1:0] o_left_out,
    output logic signed [bprs_pkg::SAMPLE_BITS-1:0] o_right_out,
    output logic                                 o_repeating
);
    import bprs_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int LW = $clog2(BUFFER_DEPTH + 1);
    localparam int FW = $clog2(CROSSFADE_LEN + 1);
    localparam int SW = SAMPLE_BITS;
    localparam logic [MUL_AW-1:0] LEN_K = MUL_AW'(60 * 16 * SAMPLE_RATE);
    localparam logic [AW-1:0]     LAST_IDX = AW'(BUFFER_DEPTH - 1);
    localparam logic [LW:0]       DEPTH_X = (LW+1)'(BUFFER_DEPTH);
    localparam logic [DIV_NW-1:0] DEPTH_Q = DIV_NW'(BUFFER_DEPTH);
    localparam logic [WET_W-1:0]  WET_TOP = WET_W'(TRANSITION_LEN);
    // ceil(2^31 / TRANSITION_LEN), exact floor division for numerators below 2^23
    localparam logic [31:0] G_RECIP =
        32'(((64'd1 << 31) + 64'(TRANSITION_LEN) - 64'd1) / 64'(TRANSITION_LEN));

    // configuration
    logic [13:0] r_bpm;
    logic [16:0] r_divq;
    logic [15:0] r_mix;
    logic [14:0] r_fb;

    // loop state
    logic [AW-1:0]    r_wi, r_ls, r_phase, r_clr_idx;
    logic [LW-1:0]    r_len;
    logic [WET_W-1:0] r_wet;
    logic             r_active, r_target;

    // item payload
    logic signed [SW-1:0] r_l_in, r_r_in;
    logic                 r_eng;
    logic [2*SW-1:0]      r_a, r_b, r_rd_data;
    logic signed [SW-1:0] r_rep_l, r_rep_r, r_wb_l, r_wb_r, r_res_l, r_res_r;
    logic                 r_res_flag;
    logic signed [SW-1:0] r_out_l, r_out_r;
    logic                 r_out_flag;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                 r_neg;
    logic [15:0]          r_g;
    logic [16:0]          r_gq;

    logic [2*SW-1:0] r_mem [BUFFER_DEPTH];

    // clamped registers
    logic [13:0] bpm_c;
    logic [16:0] divq_c;
    logic [15:0] mix_c;
    logic [14:0] fb_c;
    assign bpm_c  = (r_bpm < 14'd16) ? 14'd16 : r_bpm;
    assign divq_c = (r_divq < 17'd2048) ? 17'd2048 :
                    ((r_divq > 17'd65536) ? 17'd65536 : r_divq);
    assign mix_c  = (r_mix > 16'd32768) ? 16'd32768 : r_mix;
    assign fb_c   = (r_fb > 15'd31129) ? 15'd31129 : r_fb;

    // crossfade window and read addresses
    logic [LW-1:0] half, fval, thr;
    logic [FW-1:0] f, k;
    logic          xfade;
    logic [AW:0]   rd_sum, pos_sum;
    logic [AW-1:0] rd_addr, pos_addr;
    assign half  = r_len >> 1;
    assign fval  = (half < LW'(1)) ? LW'(1) : half;
    assign f     = (fval > LW'(CROSSFADE_LEN)) ? FW'(CROSSFADE_LEN) : fval[FW-1:0];
    assign thr   = r_len - LW'(f);
    assign xfade = LW'(r_phase) >= thr;
    assign k     = FW'(LW'(r_phase) - thr);
    assign rd_sum   = {1'b0, r_ls} + {1'b0, r_phase};
    assign rd_addr  = (rd_sum >= (AW+1)'(BUFFER_DEPTH)) ?
                      AW'(rd_sum - (AW+1)'(BUFFER_DEPTH)) : rd_sum[AW-1:0];
    assign pos_sum  = {1'b0, r_ls} + (AW+1)'(k);
    assign pos_addr = (pos_sum >= (AW+1)'(BUFFER_DEPTH)) ?
                      AW'(pos_sum - (AW+1)'(BUFFER_DEPTH)) : pos_sum[AW-1:0];

    // per channel operands
    logic                 ch;
    logic signed [SW-1:0] a_c, b_c, dry_c, rep_c;
    assign ch    = i_cmd.ch;
    assign a_c   = ch ? r_a[2*SW-1:SW] : r_a[SW-1:0];
    assign b_c   = ch ? r_b[2*SW-1:SW] : r_b[SW-1:0];
    assign dry_c = ch ? r_r_in : r_l_in;
    assign rep_c = ch ? r_rep_r : r_rep_l;

    // shared multiplier operand select
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_LMUL: begin mul_a = LEN_K;           mul_b = MUL_BW'(divq_c); end
            OP_GMUL: begin mul_a = MUL_AW'(mix_c);  mul_b = MUL_BW'(r_wet); end
            OP_XM1:  begin mul_a = MUL_AW'(a_c);    mul_b = MUL_BW'(f - k); end
            OP_XM2:  begin mul_a = MUL_AW'(b_c);    mul_b = MUL_BW'(k); end
            OP_WM:   begin mul_a = MUL_AW'(rep_c);  mul_b = MUL_BW'(fb_c); end
            OP_OM1:  begin mul_a = MUL_AW'(rep_c);  mul_b = MUL_BW'(r_g); end
            OP_OM2:  begin
                mul_a = MUL_AW'(dry_c);
                mul_b = MUL_BW'(17'd32768 - {1'b0, r_g});
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // wet gain quotient by reciprocal multiply, mix*wet stays below 2^23
    logic [54:0] g_prod;
    assign g_prod = 55'(r_prod[22:0]) * 55'(G_RECIP);

    // divider operand select
    logic              div_start, div_busy;
    logic [DIV_NW-1:0] div_num, div_quo;
    logic [DIV_DW-1:0] div_den;
    logic [ACC_W-1:0]  acc_mag;
    assign acc_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = DIV_DW'(1);
        case (i_cmd.op)
            OP_DIVLEN: begin
                div_start = 1'b1;
                div_num   = DIV_NW'(r_prod[PROD_W-1:16]);
                div_den   = bpm_c;
            end
            OP_XDIV: begin
                div_start = 1'b1;
                div_num   = acc_mag[DIV_NW-1:0];
                div_den   = DIV_DW'(f);
            end
            default: div_start = 1'b0;
        endcase
    end

    bprs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // loop capture values
    logic [LW-1:0] len_new;
    logic [LW:0]   ls_sum;
    assign len_new = (div_quo < DIV_NW'(10)) ? LW'(10) :
                     ((div_quo > DEPTH_Q) ? LW'(BUFFER_DEPTH) : div_quo[LW-1:0]);
    assign ls_sum  = {1'b0, LW'(r_wi)} +
                     ((LW'(r_wi) < len_new) ? DEPTH_X : '0) - {1'b0, len_new};

    // index, phase and gain ramp updates
    logic [AW-1:0]    wi_inc, phase_inc;
    logic [WET_W-1:0] wet_nx;
    assign wi_inc    = (r_wi == LAST_IDX) ? '0 : r_wi + 1'b1;
    assign phase_inc = (LW'(r_phase) + LW'(1) == r_len) ? '0 : r_phase + 1'b1;
    assign wet_nx    = r_target ? ((r_wet < WET_TOP) ? r_wet + 1'b1 : WET_TOP) :
                       ((r_wet != '0) ? r_wet - 1'b1 : '0);

    // memory ports
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_wa, mem_ra;
    logic [2*SW-1:0] mem_wd;
    assign mem_we = (i_cmd.op == OP_CLEAR) || (i_cmd.op == OP_BYPASS) || (i_cmd.op == OP_FIN);
    assign mem_wa = (i_cmd.op == OP_CLEAR) ? r_clr_idx : r_wi;
    assign mem_wd = (i_cmd.op == OP_CLEAR) ? '0 :
                    ((i_cmd.op == OP_BYPASS) ? {r_r_in, r_l_in} : {r_wb_r, r_wb_l});
    assign mem_re = (i_cmd.op == OP_RDA) || (i_cmd.op == OP_RDB);
    assign mem_ra = (i_cmd.op == OP_RDB) ? pos_addr : rd_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpm  <= 14'd1920;
            r_divq <= 17'd16384;
            r_mix  <= 16'd32768;
            r_fb   <= 15'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BPM:      r_bpm  <= i_cfg_data[13:0];
                CFG_DIVISION: r_divq <= i_cfg_data;
                CFG_MIX:      r_mix  <= i_cfg_data[15:0];
                CFG_FEEDBACK: r_fb   <= i_cfg_data[14:0];
                default:      r_bpm  <= r_bpm;
            endcase
        end
    end

    // loop state and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi      <= '0;
            r_ls      <= '0;
            r_len     <= LW'(1);
            r_phase   <= '0;
            r_wet     <= '0;
            r_active  <= 1'b0;
            r_target  <= 1'b0;
            r_clr_idx <= '0;
        end else begin
            case (i_cmd.op)
                OP_CLEAR:   r_clr_idx <= r_clr_idx + 1'b1;
                OP_ENG:     r_target  <= r_eng;
                OP_CAPTURE: begin
                    r_len    <= len_new;
                    r_ls     <= ls_sum[AW-1:0];
                    r_phase  <= '0;
                    r_active <= 1'b1;
                end
                OP_BYPASS:  r_wi <= wi_inc;
                OP_FIN: begin
                    r_wi    <= wi_inc;
                    r_phase <= phase_inc;
                    r_wet   <= wet_nx;
                    if (!r_target && wet_nx == '0) begin
                        r_active <= 1'b0;
                    end
                end
                default: r_wi <= r_wi;
            endcase
        end
    end

    // sample arithmetic
    logic signed [ACC_W-1:0] prod_x, wb_sum, out_sum;
    logic signed [SW-1:0]    rep_q, wb_s, out_s;
    assign prod_x  = ACC_W'(r_prod);
    assign wb_sum  = ACC_W'(dry_c) + trunc15(prod_x);
    assign out_sum = trunc15(r_acc + prod_x);
    assign wb_s    = sat_s(wb_sum);
    assign out_s   = sat_s(out_sum);
    assign rep_q   = r_neg ? SW'(~div_quo[SW-1:0] + 1'b1) : div_quo[SW-1:0];

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_l_in <= i_left_in;
                r_r_in <= i_right_in;
                r_eng  <= i_engage;
            end
            OP_LMUL, OP_GMUL, OP_XM1, OP_WM, OP_OM1: r_prod <= mul_p;
            OP_XM2, OP_OM2: begin
                r_acc  <= prod_x;
                r_prod <= mul_p;
            end
            OP_XSUM: r_acc <= r_acc + prod_x;
            OP_XDIV: r_neg <= r_acc[ACC_W-1];
            OP_DIVG: r_gq <= g_prod[47:31];
            OP_GSET: r_g <= (r_gq > 17'd32768) ? 16'd32768 : r_gq[15:0];
            OP_RDB:  r_a <= r_rd_data;
            OP_LATB: r_b <= r_rd_data;
            OP_XSET: begin
                if (ch) r_rep_r <= rep_q;
                else    r_rep_l <= rep_q;
            end
            OP_REPA: begin
                if (ch) r_rep_r <= a_c;
                else    r_rep_l <= a_c;
            end
            OP_WB: begin
                if (ch) r_wb_r <= wb_s;
                else    r_wb_l <= wb_s;
            end
            OP_OSUM: begin
                if (ch) r_res_r <= out_s;
                else    r_res_l <= out_s;
            end
            OP_BYPASS: begin
                r_res_l    <= r_l_in;
                r_res_r    <= r_r_in;
                r_res_flag <= 1'b0;
            end
            OP_FIN:  r_res_flag <= 1'b1;
            OP_PUSH: begin
                r_out_l    <= r_res_l;
                r_out_r    <= r_res_r;
                r_out_flag <= r_res_flag;
            end
            default: r_neg <= r_neg;
        endcase
    end

    // status to the controller
    assign o_stat.clr_last = (r_clr_idx == LAST_IDX);
    assign o_stat.eng_rise = r_eng && !r_target;
    assign o_stat.bypass   = !r_active && (r_wet == '0);
    assign o_stat.xfade    = xfade;
    assign o_stat.div_busy = div_busy;

    assign o_left_out  = r_out_l;
    assign o_right_out = r_out_r;
    assign o_repeating = r_out_flag;

endmodule

// ===== hw/rtl/bprs_ctrl.sv =====
// bprs_ctrl: sequencer that steps the datapath through one frame and owns the handshakes
// depends on bprs_pkg for command codes and the status struct
module bprs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  bprs_pkg::t_stat i_stat,
    output bprs_pkg::t_cmd  o_cmd
);
    import bprs_pkg::*;

    localparam logic [4:0] ST_CLEAR = 5'd0;
    localparam logic [4:0] ST_IDLE  = 5'd1;
    localparam logic [4:0] ST_ENG   = 5'd2;
    localparam logic [4:0] ST_LMUL  = 5'd3;
    localparam logic [4:0] ST_LDIV  = 5'd4;
    localparam logic [4:0] ST_LWAIT = 5'd5;
    localparam logic [4:0] ST_LCAP  = 5'd6;
    localparam logic [4:0] ST_PATH  = 5'd7;
    localparam logic [4:0] ST_GMUL  = 5'd8;
    localparam logic [4:0] ST_GDIV  = 5'd9;
    localparam logic [4:0] ST_GSET  = 5'd11;
    localparam logic [4:0] ST_RDA   = 5'd12;
    localparam logic [4:0] ST_RDB   = 5'd13;
    localparam logic [4:0] ST_LATB  = 5'd14;
    localparam logic [4:0] ST_XM1   = 5'd15;
    localparam logic [4:0] ST_XM2   = 5'd16;
    localparam logic [4:0] ST_XSUM  = 5'd17;
    localparam logic [4:0] ST_XDIV  = 5'd18;
    localparam logic [4:0] ST_XWAIT = 5'd19;
    localparam logic [4:0] ST_XSET  = 5'd20;
    localparam logic [4:0] ST_REPA  = 5'd21;
    localparam logic [4:0] ST_WM    = 5'd22;
    localparam logic [4:0] ST_WB    = 5'd23;
    localparam logic [4:0] ST_OM1   = 5'd24;
    localparam logic [4:0] ST_OM2   = 5'd25;
    localparam logic [4:0] ST_OSUM  = 5'd26;
    localparam logic [4:0] ST_FIN   = 5'd27;
    localparam logic [4:0] ST_PUSH  = 5'd28;

    logic [4:0]      r_state, n_state;
    logic            r_ch, n_ch;
    logic            r_ovld;
    logic            push;
    logic [OP_W-1:0] op;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        op      = OP_NOP;
        push    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                op = OP_CLEAR;
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_LOAD;
                    n_state = ST_ENG;
                end
            end
            ST_ENG: begin
                op      = OP_ENG;
                n_state = i_stat.eng_rise ? ST_LMUL : ST_PATH;
            end
            ST_LMUL:  begin op = OP_LMUL;   n_state = ST_LDIV; end
            ST_LDIV:  begin op = OP_DIVLEN; n_state = ST_LWAIT; end
            ST_LWAIT: if (!i_stat.div_busy) n_state = ST_LCAP;
            ST_LCAP:  begin op = OP_CAPTURE; n_state = ST_PATH; end
            ST_PATH: begin
                if (i_stat.bypass) begin
                    op      = OP_BYPASS;
                    n_state = ST_PUSH;
                end else begin
                    n_state = ST_GMUL;
                end
            end
            ST_GMUL:  begin op = OP_GMUL; n_ch = 1'b0; n_state = ST_GDIV; end
            ST_GDIV:  begin op = OP_DIVG; n_state = ST_GSET; end
            ST_GSET:  begin op = OP_GSET; n_state = ST_RDA; end
            ST_RDA:   begin op = OP_RDA;  n_state = ST_RDB; end
            ST_RDB:   begin op = OP_RDB;  n_state = ST_LATB; end
            ST_LATB: begin
                op      = OP_LATB;
                n_state = i_stat.xfade ? ST_XM1 : ST_REPA;
            end
            ST_XM1:   begin op = OP_XM1;  n_state = ST_XM2; end
            ST_XM2:   begin op = OP_XM2;  n_state = ST_XSUM; end
            ST_XSUM:  begin op = OP_XSUM; n_state = ST_XDIV; end
            ST_XDIV:  begin op = OP_XDIV; n_state = ST_XWAIT; end
            ST_XWAIT: if (!i_stat.div_busy) n_state = ST_XSET;
            ST_XSET:  begin op = OP_XSET; n_state = ST_WM; end
            ST_REPA:  begin op = OP_REPA; n_state = ST_WM; end
            ST_WM:    begin op = OP_WM;   n_state = ST_WB; end
            ST_WB:    begin op = OP_WB;   n_state = ST_OM1; end
            ST_OM1:   begin op = OP_OM1;  n_state = ST_OM2; end
            ST_OM2:   begin op = OP_OM2;  n_state = ST_OSUM; end
            ST_OSUM: begin
                op = OP_OSUM;
                if (!r_ch) begin
                    n_ch    = 1'b1;
                    n_state = i_stat.xfade ? ST_XM1 : ST_REPA;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN:   begin op = OP_FIN; n_state = ST_PUSH; end
            ST_PUSH: begin
                if (!r_ovld || i_out_ready) begin
                    op      = OP_PUSH;
                    push    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // state and output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_ch    <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            if (push) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_cmd.op    = op;
    assign o_cmd.ch    = r_ch;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovld;

endmodule

// ===== hw/rtl/beat_repeat_stutter_top.sv =====
// channel    | dir | signals                              | content
// s (input)  | in  | s_tvalid s_tready s_tdata s_tuser    | stereo frame, engage flag
// m (result) | out | m_tvalid m_tready m_tdata m_tuser    | mixed frame, repeating flag
// cfg        | in  | i_cfg_valid o_cfg_ready index data   | bpm, division, mix, feedback
//
// a bypass frame is loaded and written straight through; an effect frame runs the gain
// steps, then per channel read, crossfade or repeat, write back and mix, with a divider
// pass per channel in the crossfade window, plus the loop length division when engage
// rises. After reset the ring memory is zeroed one entry per cycle with s_tready low.
// A finished frame waits in the output register while the next one is taken;
// processing stalls only if a second result is ready before the first is taken.
// top level: controller, datapath; depends on bprs_pkg, bprs_ctrl, bprs_dp
module beat_repeat_stutter_top #(
    parameter int SAMPLE_RATE    = 48000,
    parameter int BUFFER_DEPTH   = 262144,
    parameter int CROSSFADE_LEN  = 96,
    parameter int TRANSITION_LEN = 240
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [47:0]                   s_tdata,   // left_in[23:0], right_in[47:24]
    input  logic                          s_tuser,   // engage
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,   // left_out[23:0], right_out[47:24]
    output logic                          m_tuser,   // repeating
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bprs_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [bprs_pkg::CFG_DW-1:0]   i_cfg_data
);
    import bprs_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic signed [SAMPLE_BITS-1:0] left_out, right_out;

    bprs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bprs_dp #(
        .SAMPLE_RATE    (SAMPLE_RATE),
        .BUFFER_DEPTH   (BUFFER_DEPTH),
        .CROSSFADE_LEN  (CROSSFADE_LEN),
        .TRANSITION_LEN (TRANSITION_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_left_in   (s_tdata[23:0]),
        .i_right_in  (s_tdata[47:24]),
        .i_engage    (s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_left_out  (left_out),
        .o_right_out (right_out),
        .o_repeating (m_tuser)
    );

    // config writes are always taken; a write to one of the four config registers lands in the next cycle
    assign o_cfg_ready = 1'b1;
    assign m_tdata     = {right_out, left_out};

endmodule

// ===== hw/rtl/bprs_chk.sv =====
// bprs_chk: port level checks of the stutter block, bound to the top level
// depends on bprs_pkg for the config port widths
module bprs_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [47:0]                 s_tdata,
    input logic                        s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [47:0]                 m_tdata,
    input logic                        m_tuser,
    input logic                        i_cfg_valid,
    input logic                        o_cfg_ready,
    input logic [bprs_pkg::CFG_IW-1:0] i_cfg_index,
    input logic [bprs_pkg::CFG_DW-1:0] i_cfg_data
);
    import bprs_pkg::*;

    // memory sweep follows reset, so no request is taken right after it
    a_clear_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !s_tready)
        else $error("input ready right after reset");

    // input ready drops after each request, so one frame is processed at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready again right after a request");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // config port never back-pressures
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write refused");

endmodule

bind beat_repeat_stutter_top bprs_chk u_bprs_chk (.*);

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for beat_repeat_stutter_top, stereo frames in, mixed frames out
// depends on bprs_pkg and beat_repeat_stutter_top; frame predictor lives in the stutter_board class
module tb_top;
    import bprs_pkg::*;

    localparam int RATE  = 48000;
    localparam int DEPTH = 262144;
    localparam int XF    = 96;
    localparam int RAMP  = 240;
    localparam logic [CFG_IW-1:0] CFG_SPARE = 3'd7;

    // one predicted result frame
    typedef struct {
        logic [23:0] left;
        logic [23:0] right;
        logic        repeating;
    } t_frame;

    // predictor of the stutter effect and the queue of frames it still owes
    class stutter_board;
        int          store_l[DEPTH];
        int          store_r[DEPTH];
        int unsigned wr_ptr, lp_start, lp_len, lp_phase, wet;
        bit          active, target;
        int unsigned bpm, division, mix, fbk;
        t_frame      owed[$];
        int          errors, mismatches, frames_in, frames_out, effect_frames;

        function new();
            foreach (store_l[i]) begin
                store_l[i] = 0;
                store_r[i] = 0;
            end
            wr_ptr = 0; lp_start = 0; lp_len = 1; lp_phase = 0; wet = 0;
            active = 0; target = 0;
            bpm = 1920; division = 16384; mix = 32768; fbk = 0;
        endfunction

        function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                CFG_BPM:      bpm      = 32'(val[13:0]);
                CFG_DIVISION: division = 32'(val[16:0]);
                CFG_MIX:      mix      = 32'(val[15:0]);
                CFG_FEEDBACK: fbk      = 32'(val[14:0]);
                default: ;
            endcase
        endfunction

        function longint clip(longint v);
            if (v > 64'sd8388607) return 64'sd8388607;
            if (v < -64'sd8388608) return -64'sd8388608;
            return v;
        endfunction

        // repeat, write back and mix for one channel
        function longint run_channel(bit right, longint dry, longint g, longint fb);
            int unsigned rd, f, k, pos;
            longint rep, b;
            rd  = (lp_start + lp_phase) % DEPTH;
            rep = right ? store_r[rd] : store_l[rd];
            f   = lp_len / 2;
            if (f < 1) f = 1;
            if (f > XF) f = XF;
            // crossfade back toward the loop start over the last f samples
            if (lp_phase >= lp_len - f) begin
                k   = lp_phase - (lp_len - f);
                pos = (lp_start + k) % DEPTH;
                b   = right ? store_r[pos] : store_l[pos];
                rep = (rep * longint'(f - k) + b * longint'(k)) / longint'(f);
            end
            if (right) store_r[wr_ptr] = int'(clip(dry + rep * fb / 32768));
            else       store_l[wr_ptr] = int'(clip(dry + rep * fb / 32768));
            return clip((rep * g + dry * (64'sd32768 - g)) / 32768);
        endfunction

        function void note_frame(logic [23:0] l_in, logic [23:0] r_in, bit eng);
            longint l, r, g, lo, ro, m, fb, len, bb, dv;
            t_frame e;
            l = longint'(signed'(l_in));
            r = longint'(signed'(r_in));
            frames_in++;
            // engage is looked at before the frame is processed
            if (eng != target) begin
                target = eng;
                if (eng) begin
                    bb = longint'((bpm < 16) ? 16 : bpm);
                    dv = longint'((division < 2048) ? 2048 :
                                  ((division > 65536) ? 65536 : division));
                    len = (64'd60 * RATE * 16 * dv) / (bb * 64'd65536);
                    if (len < 10) len = 10;
                    if (len > DEPTH) len = DEPTH;
                    lp_len   = int'(len);
                    lp_start = (wr_ptr + DEPTH - lp_len) % DEPTH;
                    lp_phase = 0;
                    active   = 1;
                end
            end
            if (!active && wet == 0) begin
                store_l[wr_ptr] = int'(l);
                store_r[wr_ptr] = int'(r);
                wr_ptr = (wr_ptr + 1) % DEPTH;
                e.left = l_in; e.right = r_in; e.repeating = 0;
            end else begin
                m  = longint'((mix > 32768) ? 32768 : mix);
                fb = longint'((fbk > 31129) ? 31129 : fbk);
                g  = (m * longint'(wet)) / RAMP;
                if (g > 32768) g = 32768;
                lo = run_channel(0, l, g, fb);
                ro = run_channel(1, r, g, fb);
                wr_ptr   = (wr_ptr + 1) % DEPTH;
                lp_phase = (lp_phase + 1) % lp_len;
                if (target) begin
                    if (wet < RAMP) wet++;
                end else if (wet > 0) begin
                    wet--;
                end
                if (!target && wet == 0) active = 0;
                e.left = lo[23:0]; e.right = ro[23:0]; e.repeating = 1;
                effect_frames++;
            end
            owed.push_back(e);
        endfunction

        function void check_frame(logic [23:0] l, logic [23:0] r, logic rep);
            t_frame e;
            frames_out++;
            if (owed.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result frame %h %h %b", l, r, rep);
                return;
            end
            e = owed.pop_front();
            if (l !== e.left || r !== e.right || rep !== e.repeating) begin
                errors++;
                if (mismatches++ < 10)
                    $display("frame %0d: expected L %h R %h rep %b, got L %h R %h rep %b",
                             frames_out, e.left, e.right, e.repeating, l, r, rep);
            end
        endfunction
    endclass

    logic                i_clk, i_rst_n;
    logic                s_tvalid, s_tready, s_tuser;
    logic [47:0]         s_tdata;
    logic                m_tvalid, m_tready, m_tuser;
    logic [47:0]         m_tdata;
    logic                i_cfg_valid, o_cfg_ready;
    logic [CFG_IW-1:0]   i_cfg_index;
    logic [CFG_DW-1:0]   i_cfg_data;

    stutter_board sb;
    bit  calm;
    int  cfg_writes;

    beat_repeat_stutter_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // watch both stream handshakes
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready) sb.note_frame(s_tdata[23:0], s_tdata[47:24], s_tuser);
        if (i_rst_n && m_tvalid && m_tready) sb.check_frame(m_tdata[23:0], m_tdata[47:24], m_tuser);
    end

    // result side back-pressure, a fresh random stall per result unless calm
    initial begin
        int w;
        m_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            w = calm ? 0 : $urandom_range(0, 16);
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_tvalid && m_tready)) @(posedge i_clk);
        end
    end

    task automatic send_frame(logic [23:0] l, logic [23:0] r, bit eng);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        s_tuser  <= eng;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_reg(idx, val);
        cfg_writes++;
        @(posedge i_clk);
    endtask

    // wait for every owed frame, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'(signed'($urandom_range(0, 512)) - 256);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DW-1:0] pick_val(logic [CFG_IW-1:0] idx);
        int sel;
        sel = $urandom_range(0, 5);
        case (idx)
            CFG_BPM:
                case (sel)
                    0: return CFG_DW'(16);
                    1: return CFG_DW'(16000);
                    2: return CFG_DW'($urandom_range(0, 15));
                    3: return CFG_DW'(14'h3FFF);
                    default: return CFG_DW'($urandom_range(4000, 16383));
                endcase
            CFG_DIVISION:
                case (sel)
                    0: return CFG_DW'(2048);
                    1: return CFG_DW'(65536);
                    2: return CFG_DW'($urandom_range(0, 2047));
                    3: return CFG_DW'($urandom_range(65537, 131071));
                    default: return CFG_DW'($urandom_range(2048, 20000));
                endcase
            CFG_MIX:
                case (sel)
                    0: return CFG_DW'(0);
                    1: return CFG_DW'(32768);
                    2: return CFG_DW'($urandom_range(32769, 65535));
                    default: return CFG_DW'($urandom_range(0, 32768));
                endcase
            default:
                case (sel)
                    0: return CFG_DW'(0);
                    1: return CFG_DW'(31129);
                    2: return CFG_DW'($urandom_range(31130, 32767));
                    default: return CFG_DW'($urandom_range(0, 31129));
                endcase
        endcase
    endfunction

    initial begin
        int   left_in_phase, run, total;
        bit   eng;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        calm = 0; cfg_writes = 0; total = 0;
        sb = new();
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes in bypass, engage right after reset so the loop start wraps
        send_frame(24'h7FFFFF, 24'h800000, 0);
        send_frame(24'h800000, 24'h7FFFFF, 0);
        send_frame(24'h000001, 24'hFFFFFF, 1);
        send_frame(24'h7FFFFF, 24'h7FFFFF, 1);
        send_frame(24'h800000, 24'h800000, 1);
        repeat (4) send_frame(pick_sample(), pick_sample(), 1);
        // fade out, then re-engage while still fading
        repeat (3) send_frame(pick_sample(), pick_sample(), 0);
        repeat (3) send_frame(pick_sample(), pick_sample(), 1);
        repeat (12) send_frame(pick_sample(), pick_sample(), 0);
        drain();
        total = 25;

        // extreme setting: short loop at the smallest division, full wet, strongest feedback
        write_reg(CFG_BPM, CFG_DW'(16000));
        write_reg(CFG_DIVISION, CFG_DW'(2048));
        write_reg(CFG_MIX, CFG_DW'(32768));
        write_reg(CFG_FEEDBACK, CFG_DW'(31129));
        write_reg(CFG_SPARE, 17'h1FFFF);

        // random phases: engage alternates in runs of random length that ramp the wet gain up and down
        while (total < 1400) begin
            calm = ($urandom_range(0, 3) == 0);
            left_in_phase = $urandom_range(100, 180);
            eng = 0;
            while (left_in_phase > 0) begin
                run = $urandom_range(1, 300);
                if ($urandom_range(0, 5) == 0) run = $urandom_range(1, 4);
                if (run > left_in_phase) run = left_in_phase;
                repeat (run) begin
                    // a little noise on the engage line
                    send_frame(pick_sample(), pick_sample(),
                               ($urandom_range(0, 19) == 0) ? !eng : eng);
                end
                left_in_phase -= run;
                total += run;
                eng = !eng;
            end
            drain();
            if ($urandom_range(0, 1)) write_reg(CFG_BPM, pick_val(CFG_BPM));
            if ($urandom_range(0, 1)) write_reg(CFG_DIVISION, pick_val(CFG_DIVISION));
            if ($urandom_range(0, 1)) write_reg(CFG_MIX, pick_val(CFG_MIX));
            if ($urandom_range(0, 1)) write_reg(CFG_FEEDBACK, pick_val(CFG_FEEDBACK));
            if ($urandom_range(0, 4) == 0) write_reg(CFG_SPARE, 17'($urandom));
        end
        drain();

        if (sb.owed.size() != 0) sb.errors += sb.owed.size();
        $display("frames sent %0d, through the effect %0d, results checked %0d",
                 sb.frames_in, sb.effect_frames, sb.frames_out);
        $display("register writes %0d, mismatches %0d", cfg_writes, sb.mismatches);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // hard stop if the block hangs
    initial begin
        #30000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
